### rtl/egcd_pkg.sv
package egcd_pkg;

  localparam int DATA_WIDTH = 32;
  localparam int CNT_W = $clog2(DATA_WIDTH + 1);

  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] a_value;
    logic signed [DATA_WIDTH-1:0] b_value;
  } in_item_t;

  typedef struct packed {
    logic [DATA_WIDTH-2:0] gcd_value;
    logic signed [DATA_WIDTH-1:0] coef_x;
  } out_item_t;

  typedef struct packed {
    logic [DATA_WIDTH-1:0] quotient;
    logic [DATA_WIDTH-1:0] remainder;
  } div_result_t;

endpackage

### rtl/extended_gcd_coefficient_top.sv
// extended gcd with bezout coefficient of the first operand
// input channel: in_valid / in_stall / in_item (a_value, b_value); a transfer
// happens on a rising edge with in_valid high and in_stall low
// output channel: out_valid / out_stall / out_item (gcd_value, coef_x)
// each input transfer yields exactly one output transfer
// in_stall stays high from the input transfer until the result is loaded
// into the output register, so one item is in flight at a time
// each euclid round passes through the check, the shared restoring divider,
// the multiply and the update; 32-bit operands need at most about 46 rounds
// the divider, one quotient bit per cycle, sets the round length
// a result waits in the output register while out_stall is high, and a new
// input can be taken meanwhile; its result is held back until the old one
// has been transferred
// synchronous reset empties the output register and returns to idle
module extended_gcd_coefficient_top (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  egcd_pkg::in_item_t    in_item,
  output logic                  out_valid,
  input  logic                  out_stall,
  output egcd_pkg::out_item_t   out_item
);

  localparam int W = egcd_pkg::DATA_WIDTH;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_CHECK  = 3'd1;
  localparam logic [2:0] ST_DIV    = 3'd2;
  localparam logic [2:0] ST_MUL    = 3'd3;
  localparam logic [2:0] ST_UPD    = 3'd4;
  localparam logic [2:0] ST_FINISH = 3'd5;

  logic [2:0]   state;
  logic [W-1:0] ra;
  logic [W-1:0] rb;
  logic [W-1:0] oldx;
  logic [W-1:0] x;
  logic [W-1:0] qv;
  logic [W-1:0] rc;
  logic [W-1:0] prod;

  logic [W-1:0] mag_a;
  logic [W-1:0] mag_b;
  logic         neg_a;
  logic         neg_b;
  logic         div_start;
  logic         div_done;
  logic         load_out;
  egcd_pkg::div_result_t div_res;

  assign neg_a = ra[W-1];
  assign neg_b = rb[W-1];
  assign mag_a = neg_a ? (W'(0) - ra) : ra;
  assign mag_b = neg_b ? (W'(0) - rb) : rb;

  assign div_start = (state == ST_CHECK) && (rb != '0);
  assign in_stall  = (state != ST_IDLE);
  assign load_out  = (state == ST_FINISH) && (!out_valid || !out_stall);

  egcd_divider u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (mag_a),
    .divisor  (mag_b),
    .done     (div_done),
    .result   (div_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_valid) begin
            state <= ST_CHECK;
          end
        end
        ST_CHECK: begin
          state <= (rb == '0) ? ST_FINISH : ST_DIV;
        end
        ST_DIV: begin
          if (div_done) begin
            state <= ST_MUL;
          end
        end
        ST_MUL: begin
          state <= ST_UPD;
        end
        ST_UPD: begin
          state <= ST_CHECK;
        end
        ST_FINISH: begin
          if (load_out) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // coefficients only matter modulo 2^W, so they run at W bits
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          ra   <= in_item.a_value;
          rb   <= in_item.b_value;
          oldx <= W'(1);
          x    <= '0;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          qv <= (neg_a ^ neg_b) ? (W'(0) - div_res.quotient) : div_res.quotient;
          rc <= neg_a ? (W'(0) - div_res.remainder) : div_res.remainder;
        end
      end
      ST_MUL: begin
        prod <= W'(qv * x);
      end
      ST_UPD: begin
        ra   <= rb;
        rb   <= rc;
        oldx <= x;
        x    <= oldx - prod;
      end
      ST_FINISH: begin
        if (load_out) begin
          out_item.gcd_value <= neg_a ? (W-1)'(W'(0) - ra) : ra[W-2:0];
          out_item.coef_x    <= neg_a ? (W'(0) - oldx) : oldx;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

### rtl/egcd_divider.sv
module egcd_divider (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  input  logic [egcd_pkg::DATA_WIDTH-1:0]     dividend,
  input  logic [egcd_pkg::DATA_WIDTH-1:0]     divisor,
  output logic                                done,
  output egcd_pkg::div_result_t               result
);

  localparam int W = egcd_pkg::DATA_WIDTH;

  logic [egcd_pkg::CNT_W-1:0] count;
  logic [W-1:0] quo;
  logic [W-1:0] rem;
  logic [W-1:0] dsr;
  logic [W:0]   shifted;
  logic [W+1:0] diff;

  // restoring division, one quotient bit per cycle
  assign shifted = {rem, quo[W-1]};
  assign diff    = {1'b0, shifted} - {2'b00, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        count <= egcd_pkg::CNT_W'(W);
      end else if (count != '0) begin
        count <= count - 1'b1;
        if (count == egcd_pkg::CNT_W'(1)) begin
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      dsr <= divisor;
    end else if (count != '0) begin
      if (diff[W+1]) begin
        rem <= shifted[W-1:0];
        quo <= {quo[W-2:0], 1'b0};
      end else begin
        rem <= diff[W-1:0];
        quo <= {quo[W-2:0], 1'b1};
      end
    end
  end

  assign result.quotient  = quo;
  assign result.remainder = rem;

endmodule
